// File: rtl/core/ipv6ns_pkg.sv
// ----------------------------------------------------------------------------
// IPv6 neighbour solicitation parser package
// Shared constants, status codes and the result record of the parser.
// ----------------------------------------------------------------------------
package ipv6ns_pkg;

    // packet bytes at or beyond this position are ignored
    localparam int MAX_PACKET_BYTES = 2048;
    localparam int POS_W            = $clog2(MAX_PACKET_BYTES + 1);

    localparam int OFS_W            = 11;
    // option walk arithmetic: positions, offsets and remaining length
    localparam int WALK_W           = 18;
    localparam int PLEN_W           = 16;
    localparam int LINK_W           = 48;
    localparam int WORD_W           = 64;
    localparam int NUM_WORDS        = 6;
    localparam int WORD_IDX_W       = 3;
    localparam int LINK_CNT_W       = 3;

    localparam int OPT_SRC_LINK_ADDR = 1;
    localparam int ND_OPT_UNIT_BYTES = 8;
    localparam int IPV6_HDR_BYTES    = 40;
    localparam int NS_HDR_BYTES      = 24;
    localparam int NS_TARGET_OFS     = 8;
    localparam int ADDR_FIRST_POS    = 8;
    localparam int PLEN_HI_POS       = 4;
    localparam int PLEN_LO_POS       = 5;
    localparam int LINK_ADDR_BYTES   = 6;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 440;
    localparam int M_TUSER_W = 2;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SHORT    = 2'd1,
        ST_ZERO_OPT = 2'd2,
        ST_TRUNC    = 2'd3
    } t_status;

    typedef struct packed {
        logic                  length_mismatch;
        logic                  link_addr_present;
        logic [LINK_W-1:0]     link_addr;
        logic [WORD_W-1:0]     target_low;
        logic [WORD_W-1:0]     target_high;
        logic [WORD_W-1:0]     dst_ip_low;
        logic [WORD_W-1:0]     dst_ip_high;
        logic [WORD_W-1:0]     src_ip_low;
        logic [WORD_W-1:0]     src_ip_high;
        t_status               status;
    } t_result;

endpackage

// File: rtl/core/ipv6ns_decode.sv
// ----------------------------------------------------------------------------
// IPv6 neighbour solicitation byte decoder
// Per-byte field capture, ND option walk and end-of-packet result.
// ----------------------------------------------------------------------------
module ipv6ns_decode (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  logic [7:0]                   i_data,
    input  logic                         i_last,
    input  logic [ipv6ns_pkg::OFS_W-1:0] i_offset,
    output ipv6ns_pkg::t_result          o_result
);

    localparam int POS_W  = ipv6ns_pkg::POS_W;
    localparam int WALK_W = ipv6ns_pkg::WALK_W;
    localparam int WORD_W = ipv6ns_pkg::WORD_W;
    localparam int LINK_W = ipv6ns_pkg::LINK_W;
    localparam int CNT_W  = ipv6ns_pkg::LINK_CNT_W;

    logic [POS_W-1:0]                    r_pos,        n_pos;
    logic [ipv6ns_pkg::PLEN_W-1:0]       r_plen,       n_plen;
    logic signed [WALK_W-1:0]            r_rem,        n_rem;
    logic [WALK_W-1:0]                   r_nos,        n_nos;
    logic [7:0]                          r_opt_type,   n_opt_type;
    logic [WORD_W-1:0]                   r_words [ipv6ns_pkg::NUM_WORDS];
    logic [WORD_W-1:0]                   n_words [ipv6ns_pkg::NUM_WORDS];
    logic [LINK_W-1:0]                   r_link,       n_link;
    logic                                r_link_seen,  n_link_seen;
    ipv6ns_pkg::t_status                 r_err,        n_err;
    logic                                r_walk_done,  n_walk_done;
    logic [ipv6ns_pkg::OFS_W-1:0]        r_off,        n_off;
    logic                                r_len_known,  n_len_known;
    logic [CNT_W-1:0]                    r_link_left,  n_link_left;

    logic [WALK_W-1:0]                   pos_w;
    logic [WALK_W-1:0]                   off_w;
    logic [WALK_W-1:0]                   tgt_dist;
    logic [WALK_W-1:0]                   addr_dist;
    logic [WALK_W-1:0]                   opt_bytes;
    logic [ipv6ns_pkg::PLEN_W-1:0]       plen_full;
    logic signed [WALK_W-1:0]            rem_calc;
    logic [ipv6ns_pkg::WORD_IDX_W-1:0]   widx;
    ipv6ns_pkg::t_status                 status;

    always_comb begin
        n_pos       = r_pos;
        n_plen      = r_plen;
        n_rem       = r_rem;
        n_nos       = r_nos;
        n_opt_type  = r_opt_type;
        n_words     = r_words;
        n_link      = r_link;
        n_link_seen = r_link_seen;
        n_err       = r_err;
        n_walk_done = r_walk_done;
        n_off       = (r_pos == '0) ? i_offset : r_off;
        n_len_known = r_len_known;
        n_link_left = r_link_left;

        pos_w     = WALK_W'(r_pos);
        off_w     = WALK_W'(n_off);
        addr_dist = pos_w - WALK_W'(ipv6ns_pkg::ADDR_FIRST_POS);
        tgt_dist  = pos_w - off_w - WALK_W'(ipv6ns_pkg::NS_TARGET_OFS);
        opt_bytes = WALK_W'({i_data, 3'b000});
        plen_full = {r_plen[15:8], i_data};
        rem_calc  = $signed(WALK_W'(plen_full))
                  + $signed(WALK_W'(ipv6ns_pkg::IPV6_HDR_BYTES
                                    - ipv6ns_pkg::NS_HDR_BYTES))
                  - $signed(off_w);
        widx      = '0;

        if (r_pos < POS_W'(ipv6ns_pkg::MAX_PACKET_BYTES)) begin
            if (r_pos == POS_W'(ipv6ns_pkg::PLEN_HI_POS)) begin
                n_plen = {i_data, 8'h00};
            end
            if (r_pos == POS_W'(ipv6ns_pkg::PLEN_LO_POS)) begin
                n_plen      = plen_full;
                n_rem       = rem_calc;
                n_len_known = 1'b1;
                if (rem_calc < 0) begin
                    n_err       = ipv6ns_pkg::ST_SHORT;
                    n_walk_done = 1'b1;
                end else begin
                    n_nos       = off_w + WALK_W'(ipv6ns_pkg::NS_HDR_BYTES);
                    n_walk_done = rem_calc < $signed(WALK_W'(ipv6ns_pkg::ND_OPT_UNIT_BYTES));
                end
            end
            // source and destination addresses: four words of eight bytes
            if (pos_w >= WALK_W'(ipv6ns_pkg::ADDR_FIRST_POS) &&
                pos_w < WALK_W'(ipv6ns_pkg::IPV6_HDR_BYTES)) begin
                widx          = {1'b0, addr_dist[4:3]};
                n_words[widx] = {r_words[widx][WORD_W-9:0], i_data};
            end
            if (pos_w >= off_w + WALK_W'(ipv6ns_pkg::NS_TARGET_OFS) &&
                pos_w < off_w + WALK_W'(ipv6ns_pkg::NS_TARGET_OFS + 16)) begin
                widx          = {2'b10, tgt_dist[3]};
                n_words[widx] = {r_words[widx][WORD_W-9:0], i_data};
            end
            if (r_len_known && r_err == ipv6ns_pkg::ST_OK) begin
                if (r_link_left != '0) begin
                    n_link      = {r_link[LINK_W-9:0], i_data};
                    n_link_left = r_link_left - CNT_W'(1);
                    if (n_link_left == '0) begin
                        n_link_seen = 1'b1;
                    end
                end
                if (!r_walk_done) begin
                    priority if (pos_w == r_nos) begin
                        n_opt_type = i_data;
                    end else if (pos_w == r_nos + WALK_W'(1)) begin
                        if (i_data == 8'h00) begin
                            n_err       = ipv6ns_pkg::ST_ZERO_OPT;
                            n_walk_done = 1'b1;
                        end else begin
                            if (r_opt_type == 8'(ipv6ns_pkg::OPT_SRC_LINK_ADDR)
                                && i_data == 8'h01 && !n_link_seen && n_link_left == '0) begin
                                n_link_left = CNT_W'(ipv6ns_pkg::LINK_ADDR_BYTES);
                            end
                            n_rem       = r_rem - $signed(opt_bytes);
                            n_nos       = r_nos + opt_bytes;
                            n_walk_done = (r_rem - $signed(opt_bytes))
                                        < $signed(WALK_W'(ipv6ns_pkg::ND_OPT_UNIT_BYTES));
                        end
                    end else begin
                        n_opt_type = r_opt_type;
                    end
                end
            end
            n_pos = r_pos + POS_W'(1);
        end

        priority if (!n_len_known) begin
            status = ipv6ns_pkg::ST_TRUNC;
        end else if (n_err == ipv6ns_pkg::ST_SHORT) begin
            status = ipv6ns_pkg::ST_SHORT;
        end else if (n_pos < POS_W'(ipv6ns_pkg::IPV6_HDR_BYTES) ||
                     WALK_W'(n_off) + WALK_W'(ipv6ns_pkg::NS_TARGET_OFS + 16)
                     > WALK_W'(n_pos)) begin
            status = ipv6ns_pkg::ST_TRUNC;
        end else if (!n_walk_done || n_link_left != '0) begin
            status = ipv6ns_pkg::ST_TRUNC;
        end else begin
            status = n_err;
        end

        o_result        = '0;
        o_result.status = status;
        if (status == ipv6ns_pkg::ST_OK) begin
            o_result.src_ip_high       = n_words[0];
            o_result.src_ip_low        = n_words[1];
            o_result.dst_ip_high       = n_words[2];
            o_result.dst_ip_low        = n_words[3];
            o_result.target_high       = n_words[4];
            o_result.target_low        = n_words[5];
            o_result.link_addr         = n_link_seen ? n_link : '0;
            o_result.link_addr_present = n_link_seen;
            o_result.length_mismatch   = n_rem != '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_pos       <= '0;
            r_plen      <= '0;
            r_rem       <= '0;
            r_nos       <= '0;
            r_opt_type  <= '0;
            r_words     <= '{default: '0};
            r_link      <= '0;
            r_link_seen <= 1'b0;
            r_err       <= ipv6ns_pkg::ST_OK;
            r_walk_done <= 1'b0;
            r_off       <= '0;
            r_len_known <= 1'b0;
            r_link_left <= '0;
        end else if (i_step) begin
            r_pos       <= n_pos;
            r_plen      <= n_plen;
            r_rem       <= n_rem;
            r_nos       <= n_nos;
            r_opt_type  <= n_opt_type;
            r_words     <= n_words;
            r_link      <= n_link;
            r_link_seen <= n_link_seen;
            r_err       <= n_err;
            r_walk_done <= n_walk_done;
            r_off       <= n_off;
            r_len_known <= n_len_known;
            r_link_left <= n_link_left;
        end
    end

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_last |=> r_pos == '0 && !r_len_known && r_link_left == '0)
        else $error("decoder state not cleared after last byte");

    a_pos_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(ipv6ns_pkg::MAX_PACKET_BYTES))
        else $error("byte position beyond packet limit");

    a_link_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_link_left <= CNT_W'(ipv6ns_pkg::LINK_ADDR_BYTES) &&
        !(r_link_left != '0 && r_link_seen))
        else $error("link-layer capture count inconsistent");

endmodule

// File: rtl/core/ipv6_neighbor_solicit_parser_unit.sv
// ----------------------------------------------------------------------------
// IPv6 neighbour solicitation parser unit
// Streams packet bytes in, gives one decoded result per packet on its last byte.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle; only a last byte waits, and only while the
// previous result is still held in the result register.
// Result path: the last byte is decoded from the input register straight into the
// result register, and the result is valid once it is held there.
// Reset: synchronous, active low; clears the handshake and all per-packet state.
// A new packet may start in the cycle after the last byte of the previous one.
module ipv6_neighbor_solicit_parser_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // data_byte[7:0], icmp_offset[18:8], zero padding
    input  logic [ipv6ns_pkg::S_TDATA_W-1:0]    i_s_tdata,
    input  logic                                i_s_tlast,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // src_ip_high, src_ip_low, dst_ip_high, dst_ip_low, target_high,
    // target_low, link_addr, link_addr_present, length_mismatch, zero padding
    output logic [ipv6ns_pkg::M_TDATA_W-1:0]    o_m_tdata,
    // status[1:0]
    output logic [ipv6ns_pkg::M_TUSER_W-1:0]    o_m_tuser
);

    logic                          r_s1_valid;
    logic [7:0]                    r_s1_data;
    logic                          r_s1_last;
    logic [ipv6ns_pkg::OFS_W-1:0]  r_s1_off;
    logic                          r_out_valid;
    ipv6ns_pkg::t_result           r_out;
    ipv6ns_pkg::t_result           result;
    logic                          s1_advance;

    // non-final bytes never need the result register
    assign s1_advance = r_s1_valid && (!r_s1_last || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_s1_valid || s1_advance;

    ipv6ns_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (s1_advance),
        .i_data   (r_s1_data),
        .i_last   (r_s1_last),
        .i_offset (r_s1_off),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_s1_valid <= i_s_tvalid;
            end
            if (s1_advance && r_s1_last) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_s1_data <= i_s_tdata[7:0];
            r_s1_off  <= i_s_tdata[18:8];
            r_s1_last <= i_s_tlast;
        end
        if (s1_advance && r_s1_last) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.status;
    assign o_m_tdata  = {6'b000000,
                         r_out.length_mismatch,
                         r_out.link_addr_present,
                         r_out.link_addr,
                         r_out.target_low,
                         r_out.target_high,
                         r_out.dst_ip_low,
                         r_out.dst_ip_high,
                         r_out.src_ip_low,
                         r_out.src_ip_high};

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_advance |=> r_s1_valid && $stable(r_s1_data) && $stable(r_s1_last))
        else $error("stalled byte lost from input register");

    a_err_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status != ipv6ns_pkg::ST_OK |->
        !r_out.link_addr_present && !r_out.length_mismatch && r_out.src_ip_high == '0)
        else $error("error result carries nonzero fields");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_m_tready |-> !(s1_advance && r_s1_last))
        else $error("pending result overwritten");

endmodule
